// File: design/ccre_pkg.sv
// shared constants and types for the circle center and radius estimator
// no dependencies
`default_nettype none
package ccre_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_EDGES_DEF  = 4096;

    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [10:0] HEIGHT_RST = 11'd480;
    localparam logic [7:0]  THR_RST    = 8'd200;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THR    = 2'd2;

    typedef struct packed {
        logic        circle_found;
        logic        edge_overflow;
        logic [9:0]  center_x;
        logic [9:0]  center_y;
        logic [10:0] radius;
    } t_result;
endpackage
`default_nettype wire

// File: design/ccre_if.sv
// valid/ready channel interfaces for pixel input and result output
// depends on ccre_pkg
`default_nettype none
interface ccre_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface ccre_res_if;
    logic                 valid;
    logic                 ready;
    ccre_pkg::t_result    result;
    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface
`default_nettype wire

// File: design/circle_center_radius_estimator.sv
// circle center and radius estimator top level
// depends on ccre_pkg and ccre_if
//
// channel  dir  payload
// pix      in   pixel_value (8b)
// res      out  circle_found, edge_overflow, center_x, center_y, radius
// apb      in   image_width @0, image_height @4, bright_threshold @8
//
// each pixel: the row store is read on acceptance in S_IDLE, then updated and written in S_PIX
// frame end with edges: divides of the x and y sums by the edge count, then per edge (store read,
// difference, root load, 16 root steps, accumulate), a divide of the root sum, then the result load
// frame end without edges or on overflow: straight to the result load. no reset sweep
// reset clears counters and loads config defaults; a held result stalls the next result load, and pixel intake with it
`default_nettype none
module circle_center_radius_estimator #(
    parameter int MAX_WIDTH  = ccre_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ccre_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_EDGES  = ccre_pkg::MAX_EDGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ccre_pix_if.sink         i_pix,
    ccre_res_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = $clog2(MAX_EDGES);

    typedef enum logic [3:0] {
        S_IDLE, S_PIX, S_DIVX, S_DIVY, S_RD, S_SQ, S_SQRT, S_ACC, S_DIVR, S_OUT
    } t_state;

    t_state r_state;
    logic [10:0] r_width, r_height;
    logic [7:0]  r_thr;

    logic [7:0] mem_above [MAX_WIDTH];
    logic [7:0] mem_mid [MAX_WIDTH];
    logic [CW+RW-1:0] mem_edge [MAX_EDGES];

    logic [7:0] r_pix, r_up, r_cen, r_left, r_right;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [31:0] r_sumx, r_sumy;
    logic [EW:0] r_ecnt, r_idx;
    logic r_ovf;
    logic [CW+RW-1:0] r_erd;

    // shared iterative unit registers
    logic [31:0] r_num, r_rem, r_quo, r_d2, r_rt;
    logic [5:0]  r_step;
    logic [CW-1:0] r_mx;
    logic [RW-1:0] r_my;
    logic [31:0] r_rsum;
    logic signed [CW:0] r_dx;
    logic signed [RW:0] r_dy;
    ccre_pkg::t_result r_res;
    ccre_pkg::t_result r_out;
    logic r_rvalid;

    // apb
    logic wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            ccre_pkg::REG_WIDTH:  prdata = {21'd0, r_width};
            ccre_pkg::REG_HEIGHT: prdata = {21'd0, r_height};
            ccre_pkg::REG_THR:    prdata = {24'd0, r_thr};
            default:              prdata = '0;
        endcase
    end

    // clamped size
    logic [12:0] w_c, h_c;
    always_comb begin
        w_c = {2'd0, r_width};
        if (r_width == 11'd0) w_c = 13'd1;
        else if ({2'd0, r_width} > 13'(MAX_WIDTH)) w_c = 13'(MAX_WIDTH);
        h_c = {2'd0, r_height};
        if (r_height == 11'd0) h_c = 13'd1;
        else if ({2'd0, r_height} > 13'(MAX_HEIGHT)) h_c = 13'(MAX_HEIGHT);
    end

    logic [12:0] col_e, row_e;
    logic in_win, is_edge, last_col, last_row;
    assign col_e = 13'(r_col);
    assign row_e = 13'(r_row);
    assign in_win = (row_e >= 13'd2) && (row_e - 13'd1 <= h_c - 13'd2)
                 && (col_e >= 13'd1) && (col_e + 13'd2 <= w_c);
    assign is_edge = in_win && (r_cen < r_thr) && (r_up >= r_thr || r_pix >= r_thr
                 || r_left >= r_thr || r_right >= r_thr);
    assign last_col = col_e + 13'd1 >= w_c;
    assign last_row = row_e + 13'd1 >= h_c;

    logic [CW-1:0] col_l, col_r;
    assign col_l = r_col - CW'(1);
    assign col_r = r_col + CW'(1);

    // restoring divide step: r_rem:r_num by r_d2 (divisor)
    logic [32:0] dv_try;
    assign dv_try = {r_rem, r_num[31]} - {1'b0, r_d2};

    // sqrt step: two bits per step
    logic [33:0] sq_rem2, sq_try;
    assign sq_rem2 = {r_rem, r_num[31:30]};
    assign sq_try  = sq_rem2 - {r_rt, 2'b01};

    logic [2*CW+1:0] dx_sq;
    logic [2*RW+1:0] dy_sq;
    logic [31:0] sq_prod;
    assign dx_sq   = (2*CW+2)'(r_dx) * (2*CW+2)'(r_dx);
    assign dy_sq   = (2*RW+2)'(r_dy) * (2*RW+2)'(r_dy);
    assign sq_prod = 32'(dx_sq) + 32'(dy_sq);

    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_rvalid || o_res.ready);

    assign i_pix.ready = (r_state == S_IDLE);
    assign o_res.valid = r_rvalid;
    assign o_res.result = r_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_pix.valid && i_pix.ready) begin
            r_up    <= mem_above[r_col];
            r_cen   <= mem_mid[r_col];
            r_left  <= mem_above[col_l];
            r_right <= mem_mid[col_r];
            r_pix   <= i_pix.pixel_value;
        end
        if (r_state == S_PIX) begin
            mem_above[r_col] <= r_cen;
            mem_mid[r_col]   <= r_pix;
            if (is_edge && !(r_ecnt >= (EW+1)'(MAX_EDGES)))
                mem_edge[r_ecnt[EW-1:0]] <= {r_col, RW'(r_row - RW'(1))};
        end
        if (r_state == S_RD) r_erd <= mem_edge[r_idx[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= ccre_pkg::WIDTH_RST;
            r_height <= ccre_pkg::HEIGHT_RST;
            r_thr <= ccre_pkg::THR_RST;
            r_col <= '0;
            r_row <= '0;
            r_sumx <= '0;
            r_sumy <= '0;
            r_ecnt <= '0;
            r_ovf <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            if (wr_en) begin
                unique case (paddr[3:2])
                    ccre_pkg::REG_WIDTH:  r_width <= pwdata[10:0];
                    ccre_pkg::REG_HEIGHT: r_height <= pwdata[10:0];
                    ccre_pkg::REG_THR:    r_thr <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (out_load) r_rvalid <= 1'b1;
            else if (o_res.valid && o_res.ready) r_rvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_pix.valid && i_pix.ready) begin
                        if (col_e >= 13'(MAX_WIDTH)) r_col <= CW'(MAX_WIDTH - 1);
                        r_state <= S_PIX;
                    end
                end
                S_PIX: begin
                    r_state <= S_IDLE;
                    if (is_edge) begin
                        if (r_ecnt >= (EW+1)'(MAX_EDGES)) r_ovf <= 1'b1;
                        else begin
                            r_ecnt <= r_ecnt + 1'b1;
                            r_sumx <= r_sumx + 32'(r_col);
                            r_sumy <= r_sumy + 32'(RW'(r_row - RW'(1)));
                        end
                    end
                    if (!last_col) r_col <= r_col + CW'(1);
                    else begin
                        r_col <= '0;
                        if (!last_row) r_row <= r_row + RW'(1);
                        else begin
                            r_row <= '0;
                            if (r_ovf || (is_edge && r_ecnt >= (EW+1)'(MAX_EDGES))) begin
                                r_res <= '{circle_found: 1'b0, edge_overflow: 1'b1,
                                           center_x: '0, center_y: '0, radius: '0};
                                r_state <= S_OUT;
                            end else if (r_ecnt == '0 && !is_edge) begin
                                r_res <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_num <= is_edge ? r_sumx + 32'(r_col) : r_sumx;
                                r_rem <= '0;
                                r_d2 <= 32'(is_edge ? r_ecnt + 1'b1 : r_ecnt);
                                r_step <= '0;
                                r_state <= S_DIVX;
                            end
                        end
                    end
                end
                S_DIVX, S_DIVY, S_DIVR: begin
                    if (!dv_try[32]) r_rem <= dv_try[31:0];
                    else r_rem <= {r_rem[30:0], r_num[31]};
                    r_num <= {r_num[30:0], 1'b0};
                    r_quo <= {r_quo[30:0], !dv_try[32]};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd31) begin
                        r_step <= '0;
                        r_rem <= '0;
                        if (r_state == S_DIVX) begin
                            r_mx <= CW'({r_quo[30:0], !dv_try[32]});
                            r_num <= r_sumy;
                            r_state <= S_DIVY;
                        end else if (r_state == S_DIVY) begin
                            r_my <= RW'({r_quo[30:0], !dv_try[32]});
                            r_idx <= '0;
                            r_rsum <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_res <= '{circle_found: 1'b1, edge_overflow: 1'b0,
                                       center_x: 10'(r_mx), center_y: 10'(r_my),
                                       radius: 11'({r_quo[30:0], !dv_try[32]})};
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RD: r_state <= S_SQ;
                S_SQ: begin
                    r_dx <= $signed({1'b0, r_erd[CW+RW-1:RW]}) - $signed({1'b0, r_mx});
                    r_dy <= $signed({1'b0, r_erd[RW-1:0]}) - $signed({1'b0, r_my});
                    r_step <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_step == 6'd0) begin
                        r_num <= sq_prod;
                        r_rem <= '0;
                        r_rt <= '0;
                        r_step <= 6'd1;
                    end else begin
                        if (!sq_try[33]) begin
                            r_rem <= sq_try[31:0];
                            r_rt <= {r_rt[30:0], 1'b1};
                        end else begin
                            r_rem <= sq_rem2[31:0];
                            r_rt <= {r_rt[30:0], 1'b0};
                        end
                        r_num <= {r_num[29:0], 2'b00};
                        r_step <= r_step + 6'd1;
                        if (r_step == 6'd16) r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_rsum <= r_rsum + r_rt;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_ecnt) begin
                        r_num <= r_rsum + r_rt;
                        r_rem <= '0;
                        r_step <= '0;
                        r_state <= S_DIVR;
                    end else r_state <= S_RD;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out <= r_res;
                        r_sumx <= '0;
                        r_sumy <= '0;
                        r_ecnt <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= (EW+1)'(MAX_EDGES)) else $error("edge count past depth");
    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> o_res.valid) else $error("result lost");
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.result.edge_overflow |-> !o_res.result.circle_found)
        else $error("overflow with found");
endmodule
`default_nettype wire

// File: dv/circle_center_radius_estimator_test.sv
// self-checking testbench for circle_center_radius_estimator
// streams pixel frames, writes size/threshold over apb and predicts each frame result
// depends on ccre_pkg, ccre_if and the design top level
`default_nettype none
module circle_center_radius_estimator_test;

    localparam int STALL_LIMIT = 600000;

    class circle_fit_board;
        logic [10:0] width_reg;
        logic [10:0] height_reg;
        logic [7:0]  thr_reg;
        logic [7:0]  line_above [ccre_pkg::MAX_WIDTH_DEF];
        logic [7:0]  line_mid [ccre_pkg::MAX_WIDTH_DEF];
        int          col;
        int          row;
        int unsigned sum_x;
        int unsigned sum_y;
        int          n_edges;
        int          edge_x [ccre_pkg::MAX_EDGES_DEF];
        int          edge_y [ccre_pkg::MAX_EDGES_DEF];
        bit          ovf;
        ccre_pkg::t_result fit_q [$];
        int          errors;

        function new();
            width_reg = ccre_pkg::WIDTH_RST;
            height_reg = ccre_pkg::HEIGHT_RST;
            thr_reg = ccre_pkg::THR_RST;
            foreach (line_above[i]) begin
                line_above[i] = 0;
                line_mid[i] = 0;
            end
            clear_frame();
            errors = 0;
        endfunction

        function void clear_frame();
            col = 0;
            row = 0;
            sum_x = 0;
            sum_y = 0;
            n_edges = 0;
            ovf = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                ccre_pkg::REG_WIDTH: width_reg = val[10:0];
                ccre_pkg::REG_HEIGHT: height_reg = val[10:0];
                ccre_pkg::REG_THR: thr_reg = val[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned root_floor(int unsigned v);
            int unsigned acc;
            int unsigned b;
            acc = 0;
            b = 32'h4000_0000;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= acc + b) begin
                    v -= acc + b;
                    acc = (acc >> 1) + b;
                end else begin
                    acc >>= 1;
                end
                b >>= 2;
            end
            return acc;
        endfunction

        function void note_pixel(logic [7:0] p);
            int          w;
            int          h;
            int          c;
            int          r;
            int          mx;
            int          my;
            int          dx;
            int          dy;
            longint      rsum;
            logic [7:0]  ctr;
            ccre_pkg::t_result res;
            w = (width_reg == 0) ? 1 : (width_reg > ccre_pkg::MAX_WIDTH_DEF)
                ? ccre_pkg::MAX_WIDTH_DEF : width_reg;
            h = (height_reg == 0) ? 1 : (height_reg > ccre_pkg::MAX_HEIGHT_DEF)
                ? ccre_pkg::MAX_HEIGHT_DEF : height_reg;
            c = (col >= ccre_pkg::MAX_WIDTH_DEF) ? ccre_pkg::MAX_WIDTH_DEF - 1 : col;
            r = row;
            // a height below two wraps the bottom bound in unsigned terms
            if (r >= 2 && (h < 2 || r - 1 <= h - 2) && c >= 1 && c + 2 <= w) begin
                ctr = line_mid[c];
                if (ctr < thr_reg && (line_above[c] >= thr_reg || p >= thr_reg ||
                    line_above[c - 1] >= thr_reg || line_mid[c + 1] >= thr_reg)) begin
                    if (n_edges >= ccre_pkg::MAX_EDGES_DEF) begin
                        ovf = 1;
                    end else begin
                        edge_x[n_edges] = c;
                        edge_y[n_edges] = r - 1;
                        n_edges++;
                        sum_x += c;
                        sum_y += r - 1;
                    end
                end
            end
            line_above[c] = line_mid[c];
            line_mid[c] = p;
            if (c + 1 < w) begin
                col = c + 1;
                return;
            end
            col = 0;
            if (r + 1 < h) begin
                row = r + 1;
                return;
            end
            res = '0;
            if (ovf) begin
                res.edge_overflow = 1;
            end else if (n_edges != 0) begin
                mx = sum_x / n_edges;
                my = sum_y / n_edges;
                rsum = 0;
                for (int i = 0; i < n_edges; i++) begin
                    dx = edge_x[i] - mx;
                    dy = edge_y[i] - my;
                    rsum += root_floor(dx * dx + dy * dy);
                end
                res.circle_found = 1;
                res.center_x = 10'(mx);
                res.center_y = 10'(my);
                res.radius = 11'(rsum / n_edges);
            end
            fit_q = {fit_q, res};
            clear_frame();
        endfunction

        function void check_result(ccre_pkg::t_result got);
            ccre_pkg::t_result want;
            if (fit_q.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = fit_q.pop_front();
            if (got.circle_found !== want.circle_found) begin
                $error("circle_found exp %0d got %0d", want.circle_found, got.circle_found);
                errors++;
            end
            if (got.edge_overflow !== want.edge_overflow) begin
                $error("edge_overflow exp %0d got %0d", want.edge_overflow, got.edge_overflow);
                errors++;
            end
            if (got.center_x !== want.center_x) begin
                $error("center_x exp %0d got %0d", want.center_x, got.center_x);
                errors++;
            end
            if (got.center_y !== want.center_y) begin
                $error("center_y exp %0d got %0d", want.center_y, got.center_y);
                errors++;
            end
            if (got.radius !== want.radius) begin
                $error("radius exp %0d got %0d", want.radius, got.radius);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    ccre_pix_if pix ();
    ccre_res_if res ();

    circle_center_radius_estimator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    circle_fit_board board = new();
    int src_idle = 31;
    int snk_idle = 49;
    int stall_cycles = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (res.valid && res.ready) board.check_result(res.result);
        res.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        board.set_reg(idx, val);
        psel <= 0;
        penable <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [7:0] v);
        while ($urandom_range(99) < src_idle) begin
            pix.valid <= 0;
            @(posedge i_clk);
        end
        pix.valid <= 1;
        pix.pixel_value <= v;
        do @(posedge i_clk); while (!pix.ready);
        board.note_pixel(v);
    endtask

    task automatic settle();
        pix.valid <= 0;
        while (board.fit_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic frame_setup(logic [10:0] w, logic [10:0] h, logic [7:0] thr);
        settle();
        write_reg(ccre_pkg::REG_WIDTH, 32'(w));
        write_reg(ccre_pkg::REG_HEIGHT, 32'(h));
        write_reg(ccre_pkg::REG_THR, 32'(thr));
    endtask

    function automatic logic [7:0] tone(bit bright, logic [7:0] thr);
        if (bright || thr == 0) return 8'($urandom_range(255, thr));
        return 8'($urandom_range(thr - 1, 0));
    endfunction

    // random size and threshold; disk-shaped bright blob with some noise, or all random pixels
    task automatic random_frame(output int sent);
        int          w;
        int          h;
        int          cx;
        int          cy;
        int          rr;
        int          mode;
        logic [7:0]  thr;
        bit          in_disk;
        w = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(16, 3);
        h = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
        mode = $urandom_range(9);
        thr = (mode == 0) ? 8'd0 : (mode == 1) ? 8'd255 : 8'($urandom_range(255));
        frame_setup(11'(w), 11'(h), thr);
        cx = $urandom_range(w - 1);
        cy = $urandom_range(h - 1);
        rr = $urandom_range(6);
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                in_disk = (x - cx) * (x - cx) + (y - cy) * (y - cy) <= rr * rr;
                if (mode == 2 || $urandom_range(9) == 0) send_pixel(8'($urandom_range(255)));
                else send_pixel(tone(in_disk, thr));
            end
        end
        sent = w * h;
    endtask

    initial begin
        int rand_pixels;
        int n;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        pix.valid = 0;
        pix.pixel_value = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // single dark center pixel surrounded by bright
        frame_setup(11'd3, 11'd3, 8'd200);
        for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'd0 : 8'd255);
        // all dark, no edges
        for (int i = 0; i < 9; i++) send_pixel(8'd0);
        frame_setup(11'd2, 11'd2, 8'd255);
        for (int i = 0; i < 4; i++) send_pixel(i[0] ? 8'd255 : 8'd0);
        // zero sizes act as one
        frame_setup(11'd0, 11'd0, 8'd128);
        send_pixel(8'($urandom_range(255)));
        frame_setup(11'd0, 11'd3, 8'd128);
        for (int i = 0; i < 3; i++) send_pixel(8'($urandom_range(255)));
        frame_setup(11'd3, 11'd0, 8'd1);
        for (int i = 0; i < 3; i++) send_pixel(8'($urandom_range(255)));
        frame_setup(11'd5, 11'd5, 8'd0);
        for (int i = 0; i < 25; i++) send_pixel(8'($urandom_range(255)));

        rand_pixels = 0;
        while (rand_pixels < 1240) begin
            if (rand_pixels < 413) begin
                src_idle = 31;
                snk_idle = 49;
            end else if (rand_pixels < 826) begin
                src_idle = 49;
                snk_idle = 31;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            random_frame(n);
            rand_pixels += n;
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.fit_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
design/ccre_pkg.sv
design/ccre_if.sv
design/circle_center_radius_estimator.sv
dv/circle_center_radius_estimator_test.sv
